// ===== rtl/etsp_pkg.sv =====
// shared types and constants for the extent to page read splitter
// no dependencies; used by the interfaces, the split engine and the top level
`default_nettype none

package etsp_pkg;

	// command codes of an input word
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_BEGIN  = 2'd1;
	localparam logic [1:0] CMD_EXTENT = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NSID       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFS  = 2'd3;
	localparam int CFG_DATA_W = 32;

	// field widths
	localparam int NSID_W    = 32;
	localparam int SHIFT_W   = 5;
	localparam int PAGES_W   = 9;
	localparam int OFS_W     = 21;
	localparam int PIDX_W    = 8;
	localparam int ADDR_W    = 64;
	localparam int LBA_W     = 55;
	localparam int SECS_W    = 13;
	localparam int SMO_W     = 8;
	localparam int BYTES_W   = 18;
	localparam int SECTOR_LOG2 = 9;

	// page size limits as log2 of bytes
	localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd16;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd21;

	// reset values of the configuration registers
	localparam logic [NSID_W-1:0]  NSID_RST  = 32'd1;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd16;
	localparam logic [PAGES_W-1:0] PAGES_RST = 9'd1;
	localparam logic [OFS_W-1:0]   OFS_RST   = 21'd0;

	// configuration seen by the split engine
	typedef struct packed {
		logic [NSID_W-1:0]  namespace_id;
		logic [SHIFT_W-1:0] page_shift;
		logic [PAGES_W-1:0] pages_in_use;
		logic [OFS_W-1:0]   start_offset;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/etsp_ifs.sv =====
// valid/ready channel interfaces for extent words and read command words
// depends on etsp_pkg for field widths
`default_nettype none

interface etsp_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [etsp_pkg::PIDX_W-1:0] page_index;
	logic [etsp_pkg::ADDR_W-1:0] page_address;
	logic [etsp_pkg::LBA_W-1:0]  extent_start_sector;
	logic [etsp_pkg::SECS_W-1:0] extent_sectors;
	logic final_extent;

	modport source (output valid, command, page_index, page_address, extent_start_sector,
		extent_sectors, final_extent, input ready);
	modport sink (input valid, command, page_index, page_address, extent_start_sector,
		extent_sectors, final_extent, output ready);
endinterface

interface etsp_out_if;
	logic valid;
	logic ready;
	logic [etsp_pkg::LBA_W-1:0]   start_lba;
	logic [etsp_pkg::SMO_W-1:0]   sectors_minus_one;
	logic [etsp_pkg::ADDR_W-1:0]  dest_address;
	logic [etsp_pkg::BYTES_W-1:0] byte_length;
	logic [etsp_pkg::NSID_W-1:0]  nsid_out;
	logic error;
	logic last;
	logic transfer_done;

	modport source (output valid, start_lba, sectors_minus_one, dest_address, byte_length,
		nsid_out, error, last, transfer_done, input ready);
	modport sink (input valid, start_lba, sectors_minus_one, dest_address, byte_length,
		nsid_out, error, last, transfer_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/etsp_page_ram.sv =====
// page address table: one write port, one read port, registered read data
// no dependencies
`default_nettype none

module etsp_page_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 64
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/etsp_split_eng.sv =====
// split engine: cursor, offset and error state, command cutting and output register
// depends on etsp_pkg, etsp_ifs and etsp_page_ram
`default_nettype none

module etsp_split_eng #(
	parameter int PAGE_SLOTS         = 256,
	parameter int MAX_CMD_SECTORS    = 256,
	parameter int MAX_EXTENT_SECTORS = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire etsp_pkg::cfg_t cfg,
	etsp_in_if.sink            extent,
	etsp_out_if.source         cmd
);

	localparam int IDX_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
	localparam int CUR_W = $clog2(PAGE_SLOTS + 1);
	localparam int LIM_W = (CUR_W > etsp_pkg::PAGES_W) ? CUR_W : etsp_pkg::PAGES_W;
	localparam int LDW   = (IDX_W + 1 > etsp_pkg::PIDX_W) ? IDX_W + 1 : etsp_pkg::PIDX_W;
	localparam int MC_W  = $clog2(MAX_CMD_SECTORS + 1);
	localparam int TW    = (MC_W > etsp_pkg::SECS_W) ? MC_W : etsp_pkg::SECS_W;
	localparam int ME_W  = $clog2(MAX_EXTENT_SECTORS + 1);
	localparam int EW    = (ME_W > etsp_pkg::SECS_W) ? ME_W : etsp_pkg::SECS_W;
	localparam int PS_W  = etsp_pkg::OFS_W + 1;
	localparam int SW    = etsp_pkg::SECS_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_CALC = 3'd2;
	localparam logic [2:0] S_ERR  = 3'd3;

	logic [2:0] state_q;
	logic [CUR_W-1:0] cursor_q;
	logic [etsp_pkg::OFS_W-1:0] offset_q;
	logic err_q;
	logic [etsp_pkg::LBA_W-1:0] lba_q;
	logic [SW-1:0] left_q;
	logic final_q;
	logic [SW-1:0] remain_q;
	logic ov_q;

	logic in_acc;
	logic slot_free;
	logic o_load;
	logic pages_gone;

	// page table memory
	logic ram_we;
	logic ram_re;
	logic [LDW-1:0] ld_idx;
	logic [etsp_pkg::ADDR_W-1:0] ram_rdata;

	assign ld_idx = LDW'(extent.page_index);
	assign in_acc = extent.valid && extent.ready;
	assign ram_we = in_acc && (extent.command == etsp_pkg::CMD_LOAD) &&
		(ld_idx < LDW'(PAGE_SLOTS));
	assign ram_re = (state_q == S_CHK) && !pages_gone;

	etsp_page_ram #(
		.DEPTH (PAGE_SLOTS),
		.AW    (IDX_W),
		.DW    (etsp_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ld_idx[IDX_W-1:0]),
		.wdata (extent.page_address),
		.re    (ram_re),
		.raddr (cursor_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// page size and room left in the current page
	logic [etsp_pkg::SHIFT_W-1:0] shift_c;
	logic [PS_W-1:0] psize;
	logic [PS_W-1:0] offset_ext;
	logic [PS_W-1:0] room;
	logic [SW-1:0] remain_c;
	logic [LIM_W-1:0] lim;

	always_comb begin
		if (cfg.page_shift < etsp_pkg::SHIFT_MIN) begin
			shift_c = etsp_pkg::SHIFT_MIN;
		end else if (cfg.page_shift > etsp_pkg::SHIFT_MAX) begin
			shift_c = etsp_pkg::SHIFT_MAX;
		end else begin
			shift_c = cfg.page_shift;
		end
		psize = PS_W'(1) << shift_c;
		offset_ext = PS_W'(offset_q);
		room = psize - offset_ext;
		remain_c = (offset_ext >= psize) ? '0 : room[PS_W-1:etsp_pkg::SECTOR_LOG2];
		lim = (LIM_W'(cfg.pages_in_use) > LIM_W'(PAGE_SLOTS)) ? LIM_W'(PAGE_SLOTS) :
			LIM_W'(cfg.pages_in_use);
		pages_gone = (LIM_W'(cursor_q) >= lim) || (remain_c == '0);
	end

	// length of the next command and its side effects
	logic [SW-1:0] t_lr;
	logic [SW-1:0] take_c;
	logic [SW-1:0] take_m1;
	logic [PS_W-1:0] off_sum;
	logic last_c;
	logic too_long;

	always_comb begin
		t_lr = (left_q < remain_q) ? left_q : remain_q;
		take_c = (TW'(t_lr) > TW'(MAX_CMD_SECTORS)) ? SW'(MAX_CMD_SECTORS) : t_lr;
		take_m1 = take_c - SW'(1);
		off_sum = offset_ext + {take_c, {etsp_pkg::SECTOR_LOG2{1'b0}}};
		last_c = (take_c == left_q);
		too_long = EW'(extent.extent_sectors) > EW'(MAX_EXTENT_SECTORS);
	end

	assign slot_free = !ov_q || cmd.ready;
	assign o_load = ((state_q == S_CALC) || (state_q == S_ERR)) && slot_free;
	assign extent.ready = (state_q == S_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			offset_q <= '0;
			err_q    <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (o_load) begin
				ov_q <= 1'b1;
			end else if (cmd.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (extent.command)
							etsp_pkg::CMD_BEGIN: begin
								cursor_q <= '0;
								offset_q <= cfg.start_offset;
								err_q    <= 1'b0;
							end
							etsp_pkg::CMD_EXTENT: begin
								if (!err_q) begin
									if (too_long) begin
										state_q <= S_ERR;
									end else if (extent.extent_sectors != '0) begin
										state_q <= S_CHK;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_CHK: begin
					if (pages_gone) begin
						err_q   <= 1'b1;
						state_q <= S_ERR;
					end else begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (slot_free) begin
						if (off_sum >= psize) begin
							offset_q <= '0;
							cursor_q <= cursor_q + CUR_W'(1);
						end else begin
							offset_q <= off_sum[etsp_pkg::OFS_W-1:0];
						end
						state_q <= last_c ? S_IDLE : S_CHK;
					end
				end
				S_ERR: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// extent progress, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lba_q   <= extent.extent_start_sector;
			left_q  <= extent.extent_sectors;
			final_q <= extent.final_extent;
		end else if (state_q == S_CALC && slot_free) begin
			lba_q  <= lba_q + etsp_pkg::LBA_W'(take_c);
			left_q <= left_q - take_c;
		end
		if (state_q == S_CHK) begin
			remain_q <= remain_c;
		end
	end

	// output word register
	logic [etsp_pkg::LBA_W-1:0]   o_lba_q;
	logic [etsp_pkg::SMO_W-1:0]   o_smo_q;
	logic [etsp_pkg::ADDR_W-1:0]  o_dest_q;
	logic [etsp_pkg::BYTES_W-1:0] o_bytes_q;
	logic [etsp_pkg::NSID_W-1:0]  o_nsid_q;
	logic o_err_q;
	logic o_last_q;
	logic o_done_q;

	always_ff @(posedge clk) begin
		if (state_q == S_CALC && slot_free) begin
			o_lba_q   <= lba_q;
			o_smo_q   <= take_m1[etsp_pkg::SMO_W-1:0];
			o_dest_q  <= ram_rdata + etsp_pkg::ADDR_W'(offset_q);
			o_bytes_q <= {take_c[etsp_pkg::SMO_W:0], {etsp_pkg::SECTOR_LOG2{1'b0}}};
			o_nsid_q  <= cfg.namespace_id;
			o_err_q   <= 1'b0;
			o_last_q  <= last_c;
			o_done_q  <= final_q && last_c;
		end else if (state_q == S_ERR && slot_free) begin
			o_lba_q   <= '0;
			o_smo_q   <= '0;
			o_dest_q  <= '0;
			o_bytes_q <= '0;
			o_nsid_q  <= '0;
			o_err_q   <= 1'b1;
			o_last_q  <= 1'b1;
			o_done_q  <= 1'b0;
		end
	end

	assign cmd.valid             = ov_q;
	assign cmd.start_lba         = o_lba_q;
	assign cmd.sectors_minus_one = o_smo_q;
	assign cmd.dest_address      = o_dest_q;
	assign cmd.byte_length       = o_bytes_q;
	assign cmd.nsid_out          = o_nsid_q;
	assign cmd.error             = o_err_q;
	assign cmd.last              = o_last_q;
	assign cmd.transfer_done     = o_done_q;

endmodule

`default_nettype wire

// ===== rtl/extent_to_page_read_splitter.sv =====
// extent to page read splitter: configuration registers around the split engine
// an extent word is taken while idle; each command then takes a cursor check, then a page table
// read and cut into the output register once it is free; the input is not ready again until the
// last command of an extent is cut, while load and begin words leave the splitter idle
// a finished word waits in the output register while the next input is taken
// reset (arst_n low) clears cursor, offset, error flag and registers; the page table is not cleared
`default_nettype none

module extent_to_page_read_splitter #(
	parameter int PAGE_SLOTS         = 256,
	parameter int MAX_CMD_SECTORS    = 256,
	parameter int MAX_EXTENT_SECTORS = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [etsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [etsp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	etsp_in_if.sink                                 extent,
	etsp_out_if.source                              cmd
);

	etsp_pkg::cfg_t cfg_q;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.namespace_id <= etsp_pkg::NSID_RST;
			cfg_q.page_shift   <= etsp_pkg::SHIFT_RST;
			cfg_q.pages_in_use <= etsp_pkg::PAGES_RST;
			cfg_q.start_offset <= etsp_pkg::OFS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				etsp_pkg::REG_NSID:       cfg_q.namespace_id <= cfg_wdata;
				etsp_pkg::REG_PAGE_SHIFT: cfg_q.page_shift <= cfg_wdata[etsp_pkg::SHIFT_W-1:0];
				etsp_pkg::REG_PAGES:      cfg_q.pages_in_use <= cfg_wdata[etsp_pkg::PAGES_W-1:0];
				etsp_pkg::REG_START_OFS:  cfg_q.start_offset <= cfg_wdata[etsp_pkg::OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// command cutting and page table
	etsp_split_eng #(
		.PAGE_SLOTS         (PAGE_SLOTS),
		.MAX_CMD_SECTORS    (MAX_CMD_SECTORS),
		.MAX_EXTENT_SECTORS (MAX_EXTENT_SECTORS)
	) u_eng (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.extent (extent),
		.cmd    (cmd)
	);

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking bench for extent_to_page_read_splitter: directed and random extent words
// needs etsp_pkg, etsp_ifs and the splitter rtl; predicts read commands and checks each word
`timescale 1ns / 100ps

module tb_top;
	import etsp_pkg::*;

	localparam int PAGE_SLOTS         = 256;
	localparam int MAX_CMD_SECTORS    = 256;
	localparam int MAX_EXTENT_SECTORS = 4096;
	localparam int SETTLE_CYCLES      = 80;
	localparam int CYCLE_LIMIT        = 1000000;
	localparam int SQUEEZE_CYCLES     = 300;
	localparam int FILL_SLOTS         = 32;
	localparam int PHASE_WORDS        = 11;
	localparam logic [1:0] CMD_UNDEF  = 2'd3;

	typedef struct packed {
		logic [1:0]          command;
		logic [PIDX_W-1:0]   page_index;
		logic [ADDR_W-1:0]   page_address;
		logic [LBA_W-1:0]    extent_start_sector;
		logic [SECS_W-1:0]   extent_sectors;
		logic                final_extent;
	} ext_word_t;

	typedef struct packed {
		logic [LBA_W-1:0]    start_lba;
		logic [SMO_W-1:0]    sectors_minus_one;
		logic [ADDR_W-1:0]   dest_address;
		logic [BYTES_W-1:0]  byte_length;
		logic [NSID_W-1:0]   nsid_out;
		logic                error;
		logic                last;
		logic                transfer_done;
	} cmd_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	etsp_in_if  ext_if ();
	etsp_out_if cmd_if ();

	extent_to_page_read_splitter #(
		.PAGE_SLOTS        (PAGE_SLOTS),
		.MAX_CMD_SECTORS   (MAX_CMD_SECTORS),
		.MAX_EXTENT_SECTORS(MAX_EXTENT_SECTORS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.extent   (ext_if),
		.cmd      (cmd_if)
	);

	// shadow of the splitter state and its registers
	logic [ADDR_W-1:0]  page_tbl [PAGE_SLOTS];
	int unsigned        cursor = 0;
	int unsigned        offset = 0;
	logic               halted = 1'b0;
	logic [NSID_W-1:0]  nsid_cfg = NSID_RST;
	logic [SHIFT_W-1:0] shift_cfg = SHIFT_RST;
	logic [PAGES_W-1:0] pages_cfg = PAGES_RST;
	logic [OFS_W-1:0]   start_ofs = OFS_RST;

	ext_word_t   extent_words [$];
	cmd_word_t   expected_cmds [$];
	ext_word_t   drv_word;
	logic        ext_taken = 1'b0;
	int unsigned idle_pct = 0;
	int unsigned send_gap = 0;
	int unsigned hold_left = 0;
	logic        squeeze_armed = 1'b0;
	logic        squeeze_done = 1'b0;
	int unsigned queued = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycles = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cut one input word into the read commands it should cause
	task automatic split_word(input ext_word_t w);
		int unsigned psize, pages, remain, take, left;
		logic [SHIFT_W-1:0] sh;
		logic [LBA_W-1:0] lba;
		cmd_word_t c;
		cmd_word_t outs [$];
		case (w.command)
			CMD_LOAD: begin
				page_tbl[w.page_index] = w.page_address;
			end
			CMD_BEGIN: begin
				cursor = 0;
				offset = start_ofs;
				halted = 1'b0;
			end
			CMD_EXTENT: begin
				if (!halted) begin
					sh = shift_cfg < SHIFT_MIN ? SHIFT_MIN :
						(shift_cfg > SHIFT_MAX ? SHIFT_MAX : shift_cfg);
					psize = 1 << sh;
					pages = pages_cfg < PAGE_SLOTS ? pages_cfg : PAGE_SLOTS;
					lba = w.extent_start_sector;
					left = w.extent_sectors;
					if (left > MAX_EXTENT_SECTORS) begin
						// too long: one error word, cursor untouched
						c = '0;
						c.error = 1'b1;
						outs.push_back(c);
					end else begin
						while (left != 0) begin
							if (cursor >= pages || offset >= psize)
								remain = 0;
							else
								remain = (psize - offset) >> SECTOR_LOG2;
							// out of pages: error word, then ignore extents until begin
							if (remain == 0) begin
								c = '0;
								c.error = 1'b1;
								outs.push_back(c);
								halted = 1'b1;
								break;
							end
							take = left;
							if (take > MAX_CMD_SECTORS)
								take = MAX_CMD_SECTORS;
							if (take > remain)
								take = remain;
							c = '0;
							c.start_lba = lba;
							c.sectors_minus_one = SMO_W'(take - 1);
							c.dest_address = page_tbl[cursor] + ADDR_W'(offset);
							c.byte_length = BYTES_W'(take << SECTOR_LOG2);
							c.nsid_out = nsid_cfg;
							c.transfer_done = w.final_extent && (take == left);
							outs.push_back(c);
							lba = lba + LBA_W'(take);
							left = left - take;
							offset = offset + (take << SECTOR_LOG2);
							if (offset >= psize) begin
								offset = 0;
								cursor++;
							end
						end
					end
					if (outs.size() != 0)
						outs[outs.size() - 1].last = 1'b1;
					foreach (outs[i])
						expected_cmds.push_back(outs[i]);
				end
			end
			default: ;
		endcase
	endtask

	// input side: note each accepted word and predict from it
	always @(posedge clk) begin
		ext_taken <= arst_n && ext_if.valid && ext_if.ready;
		if (arst_n && ext_if.valid && ext_if.ready)
			split_word({ext_if.command, ext_if.page_index, ext_if.page_address,
				ext_if.extent_start_sector, ext_if.extent_sectors, ext_if.final_extent});
	end

	// extent word driver with random idle bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			ext_if.valid <= 1'b0;
		end else if (!ext_if.valid || ext_taken) begin
			if (send_gap != 0) begin
				send_gap--;
				ext_if.valid <= 1'b0;
			end else if (extent_words.size() != 0 && $urandom_range(99) < idle_pct) begin
				send_gap = $urandom_range(13, 0);
				ext_if.valid <= 1'b0;
			end else if (extent_words.size() != 0) begin
				drv_word = extent_words.pop_front();
				ext_if.command <= drv_word.command;
				ext_if.page_index <= drv_word.page_index;
				ext_if.page_address <= drv_word.page_address;
				ext_if.extent_start_sector <= drv_word.extent_start_sector;
				ext_if.extent_sectors <= drv_word.extent_sectors;
				ext_if.final_extent <= drv_word.final_extent;
				ext_if.valid <= 1'b1;
			end else begin
				ext_if.valid <= 1'b0;
			end
		end
	end

	// command word receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			cmd_if.ready <= 1'b0;
		end else if (squeeze_armed && !squeeze_done && expected_cmds.size() != 0) begin
			squeeze_done = 1'b1;
			hold_left = SQUEEZE_CYCLES - 1;
			cmd_if.ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			hold_left = $urandom_range(13, 0);
			cmd_if.ready <= 1'b0;
		end else begin
			cmd_if.ready <= 1'b1;
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// compare each command word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			if (expected_cmds.size() == 0) begin
				$error("read command word arrived with none expected");
				mismatch_count++;
			end else begin
				check_field("start_lba", expected_cmds[0].start_lba, cmd_if.start_lba);
				check_field("sectors_minus_one", expected_cmds[0].sectors_minus_one,
					cmd_if.sectors_minus_one);
				check_field("dest_address", expected_cmds[0].dest_address, cmd_if.dest_address);
				check_field("byte_length", expected_cmds[0].byte_length, cmd_if.byte_length);
				check_field("nsid_out", expected_cmds[0].nsid_out, cmd_if.nsid_out);
				check_field("error", expected_cmds[0].error, cmd_if.error);
				check_field("last", expected_cmds[0].last, cmd_if.last);
				check_field("transfer_done", expected_cmds[0].transfer_done,
					cmd_if.transfer_done);
				void'(expected_cmds.pop_front());
			end
		end
	end

	// run time limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic ext_word_t noise_word();
		ext_word_t w;
		w.command = 2'($urandom);
		w.page_index = PIDX_W'($urandom);
		w.page_address = {$urandom, $urandom};
		w.extent_start_sector = LBA_W'({$urandom, $urandom});
		w.extent_sectors = SECS_W'($urandom);
		w.final_extent = 1'($urandom);
		return w;
	endfunction

	task automatic post_word(input ext_word_t w);
		extent_words.push_back(w);
		queued++;
	endtask

	task automatic queue_load(input logic [PIDX_W-1:0] idx, input logic [ADDR_W-1:0] addr);
		ext_word_t w;
		w = noise_word();
		w.command = CMD_LOAD;
		w.page_index = idx;
		w.page_address = addr;
		post_word(w);
	endtask

	task automatic queue_begin();
		ext_word_t w;
		w = noise_word();
		w.command = CMD_BEGIN;
		post_word(w);
	endtask

	task automatic queue_extent(input logic [LBA_W-1:0] lba, input int unsigned secs,
		input logic fin);
		ext_word_t w;
		w = noise_word();
		w.command = CMD_EXTENT;
		w.extent_start_sector = lba;
		w.extent_sectors = SECS_W'(secs);
		w.final_extent = fin;
		post_word(w);
	endtask

	// begin followed by a few extents, the last one marked final
	task automatic queue_transfer();
		int unsigned n_ext, pick, secs;
		logic [LBA_W-1:0] lba;
		n_ext = $urandom_range(1, 4);
		queue_begin();
		for (int i = 0; i < n_ext; i++) begin
			pick = $urandom_range(99);
			if (pick < 80)
				secs = $urandom_range(1, 300);
			else if (pick < 95)
				secs = $urandom_range(301, MAX_EXTENT_SECTORS);
			else
				secs = MAX_EXTENT_SECTORS;
			if ($urandom_range(4) == 0)
				lba = '1 - LBA_W'($urandom_range(600));
			else
				lba = LBA_W'({$urandom, $urandom});
			queue_extent(lba, secs, i == n_ext - 1);
		end
	endtask

	// stray words: undefined command, reloads, odd extents, lone begin
	task automatic queue_noise();
		ext_word_t w;
		case ($urandom_range(4))
			0: begin
				w = noise_word();
				w.command = CMD_UNDEF;
				post_word(w);
			end
			1: queue_load(PIDX_W'($urandom), {$urandom, $urandom});
			2: queue_extent(LBA_W'({$urandom, $urandom}), $urandom_range(8191), 1'($urandom));
			3: queue_begin();
			default: queue_extent(LBA_W'({$urandom, $urandom}), 0, 1'b1);
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_NSID:       nsid_cfg = val;
			REG_PAGE_SHIFT: shift_cfg = val[SHIFT_W-1:0];
			REG_PAGES:      pages_cfg = val[PAGES_W-1:0];
			REG_START_OFS:  start_ofs = val[OFS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [NSID_W-1:0] nsid, input int unsigned sh,
		input int unsigned pages, input int unsigned ofs);
		write_reg(REG_NSID, nsid);
		write_reg(REG_PAGE_SHIFT, CFG_DATA_W'(sh));
		write_reg(REG_PAGES, CFG_DATA_W'(pages));
		write_reg(REG_START_OFS, CFG_DATA_W'(ofs));
	endtask

	// wait until every word is taken and every command has come back, or the wait limit runs out
	task automatic drain();
		int unsigned waited;
		waited = 0;
		while (extent_words.size() != 0 || ext_if.valid)
			@(negedge clk);
		while (expected_cmds.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned sh, pages, psz, ofs, mark, base;
		logic [NSID_W-1:0] nsid;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		ext_if.valid = 1'b0;
		ext_if.command = CMD_LOAD;
		ext_if.page_index = '0;
		ext_if.page_address = '0;
		ext_if.extent_start_sector = '0;
		ext_if.extent_sectors = '0;
		ext_if.final_extent = 1'b0;
		cmd_if.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: one 64 KB page, base near the top so the address wraps
		idle_pct = 20;
		queue_load(8'd0, 64'hFFFF_FFFF_FFFF_8000);
		queue_load(8'd255, 64'h0);
		begin
			ext_word_t w;
			w = noise_word();
			w.command = CMD_UNDEF;
			post_word(w);
		end
		queue_extent('0, 0, 1'b1);
		queue_extent('0, 1, 1'b1);
		queue_extent('1, 100, 1'b0);
		queue_extent(LBA_W'(55'h12_3456_789A), MAX_EXTENT_SECTORS, 1'b1);
		queue_extent('0, 5, 1'b1);
		queue_extent('0, 8191, 1'b1);
		queue_begin();
		queue_extent('0, MAX_EXTENT_SECTORS + 1, 1'b0);
		queue_extent('1, 8191, 1'b1);
		queue_extent(LBA_W'(1000), 127, 1'b0);
		queue_extent(LBA_W'(1127), 2, 1'b1);
		queue_begin();
		queue_extent(LBA_W'(7), 128, 1'b1);
		drain();

		// 2 MB pages with start offset leaving less than one sector
		write_all('1, 21, 2, 2097151);
		queue_load(8'd1, 64'h0000_0001_0000_0000);
		queue_begin();
		queue_extent(LBA_W'(9), 5, 1'b1);
		drain();

		// one sector left in page 0, then the sector number wraps
		write_all('0, 21, 2, 2097152 - 512);
		queue_begin();
		queue_extent('1 - LBA_W'(1), 600, 1'b1);
		drain();

		// fill the low table slots in scrambled order
		idle_pct = 30;
		base = $urandom_range(FILL_SLOTS - 1);
		for (int i = 0; i < FILL_SLOTS; i++)
			queue_load(PIDX_W'((i * 13 + base) % FILL_SLOTS), i == 0 ? '1 : {$urandom, $urandom});
		drain();

		// random phases under changing settings, mostly well-formed transfers
		for (int k = 0; k < 6; k++) begin
			sh = k == 0 ? 16 : (k == 1 ? 21 : $urandom_range(16, 21));
			pages = (k == 0 || k == 3) ? FILL_SLOTS : (k == 1 ? 1 : $urandom_range(2, 6));
			psz = 1 << sh;
			if (k == 2)
				ofs = psz - 512 * $urandom_range(1, 4);
			else if ($urandom_range(1) == 0)
				ofs = $urandom_range(psz / 512 - 1) * 512;
			else
				ofs = $urandom_range(psz - 1);
			nsid = k == 0 ? '0 : NSID_W'($urandom);
			write_all(nsid, sh, pages, ofs);
			case (k)
				0: idle_pct = 25;
				1: idle_pct = 0;
				2: idle_pct = 40;
				3: idle_pct = 15;
				4: idle_pct = 30;
				default: idle_pct = 0;
			endcase
			mark = queued;
			while (queued - mark < PHASE_WORDS) begin
				if ($urandom_range(99) < 75)
					queue_transfer();
				else
					queue_noise();
			end
			if (k == 0)
				squeeze_armed = 1'b1;
			drain();
		end

		if (expected_cmds.size() != 0) begin
			$error("%0d read command words never arrived", expected_cmds.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
